### rtl/core/mbwrfr_pkg.sv
`default_nettype none

package mbwrfr_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_STATION_ADDRESS   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_FUNCTION = 8'd1;

  localparam logic [7:0] STATION_ADDRESS_RESET   = 8'h01;
  localparam logic [7:0] EXPECTED_FUNCTION_RESET = 8'h06;

  // Modbus CRC16, reflected form.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Positions within a frame, counted as bytes taken so far.
  localparam logic [2:0] POS_AFTER_ADDRESS  = 3'd1;
  localparam logic [2:0] POS_AFTER_FUNCTION = 3'd2;
  localparam logic [2:0] POS_REGISTER_LOW   = 3'd3;
  localparam logic [2:0] POS_VALUE_LOW      = 3'd5;
  localparam logic [2:0] POS_CRC_LOW        = 3'd6;
  localparam logic [2:0] POS_CRC_HIGH       = 3'd7;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_FUNC = 3'd1,
    PH_BODY = 3'd2,
    PH_CRC  = 3'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] station_address;
    logic [7:0] expected_function;
  } cfg_t;

  typedef struct packed {
    logic       frame_good;
    logic [7:0] register_low;
    logic [7:0] value_low;
  } result_t;

  // One byte through the CRC, one bit per step.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/core/modbus_write_register_frame_receiver_top.sv
// Modbus RTU write-single-register frame receiver.
//
// Bytes from the serial line enter on the input channel (in_valid, in_stall,
// rx_byte), one per transaction. The block hunts for the station address,
// checks the function code, collects the four body bytes and the two CRC
// bytes, and on the eighth byte of a frame issues one result transaction
// (frame_good, register_low, value_low) on the output channel
// (out_valid, out_stall). Bytes outside a frame produce nothing.
// The two configuration registers, station address and expected function
// code, are written through cfg_valid, cfg_ready, cfg_index and cfg_data;
// the user must do so only while the block is idle, which the block itself
// does not enforce; cfg_ready is always high. A byte is taken into an
// input register and processed from there; the result goes to the output
// register. One byte can be accepted in every cycle unless the input stalls,
// with the whole CRC byte update between the input and result registers.
// If the receiver stalls, the result waits in the output register; bytes
// that produce no result keep flowing, and the input stalls only when a
// further frame completes while the earlier result is still waiting.
// Synchronous reset restores the default station address 0x01 and function
// code 0x06, empties both registers and restarts the hunt for an address.

`default_nettype none

module modbus_write_register_frame_receiver_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [mbwrfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]                         cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [7:0]                         rx_byte,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    frame_good,
  output logic [7:0]                              register_low,
  output logic [7:0]                              value_low
);

  mbwrfr_pkg::cfg_t    cfg;
  mbwrfr_pkg::result_t res;
  logic                res_load;
  logic                out_free;

  mbwrfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mbwrfr_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .cfg      (cfg),
    .out_free (out_free),
    .res_load (res_load),
    .res      (res)
  );

  mbwrfr_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .res_load     (res_load),
    .res          (res),
    .out_free     (out_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_good   (frame_good),
    .register_low (register_low),
    .value_low    (value_low)
  );

endmodule

`default_nettype wire

### rtl/core/mbwrfr_cfg_regs.sv
`default_nettype none

module mbwrfr_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [mbwrfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]                         cfg_data,
  output mbwrfr_pkg::cfg_t                        cfg
);

  // Writes are always taken; indexes beyond the register list are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.station_address   <= mbwrfr_pkg::STATION_ADDRESS_RESET;
      cfg.expected_function <= mbwrfr_pkg::EXPECTED_FUNCTION_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mbwrfr_pkg::REG_STATION_ADDRESS:   cfg.station_address   <= cfg_data;
        mbwrfr_pkg::REG_EXPECTED_FUNCTION: cfg.expected_function <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/mbwrfr_parser.sv
`default_nettype none

module mbwrfr_parser (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           rx_byte,
  input  wire mbwrfr_pkg::cfg_t     cfg,
  input  wire logic                 out_free,
  output logic                      res_load,
  output mbwrfr_pkg::result_t       res
);

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_byte;

  // Frame state.
  mbwrfr_pkg::phase_t phase, phase_next;
  logic [2:0]  byte_count, byte_count_next;
  logic [15:0] crc_acc, crc_acc_next;
  logic [7:0]  held_register, held_register_next;
  logic [7:0]  held_value, held_value_next;
  logic        crc_low_match, crc_low_match_next;
  logic        res_valid;
  logic        advance;

  always_comb begin
    phase_next         = phase;
    byte_count_next    = byte_count;
    crc_acc_next       = crc_acc;
    held_register_next = held_register;
    held_value_next    = held_value;
    crc_low_match_next = crc_low_match;
    res_valid          = 1'b0;
    res.frame_good     = 1'b0;
    res.register_low   = held_register;
    res.value_low      = held_value;
    case (phase)
      mbwrfr_pkg::PH_FUNC: begin
        if (s1_byte == cfg.expected_function) begin
          crc_acc_next    = mbwrfr_pkg::crc_feed(crc_acc, s1_byte);
          byte_count_next = mbwrfr_pkg::POS_AFTER_FUNCTION;
          phase_next      = mbwrfr_pkg::PH_BODY;
        end else begin
          phase_next         = mbwrfr_pkg::PH_HUNT;
          byte_count_next    = 3'd0;
          crc_acc_next       = mbwrfr_pkg::CRC_INIT;
          crc_low_match_next = 1'b0;
        end
      end
      mbwrfr_pkg::PH_BODY: begin
        crc_acc_next = mbwrfr_pkg::crc_feed(crc_acc, s1_byte);
        if (byte_count == mbwrfr_pkg::POS_REGISTER_LOW) begin
          held_register_next = s1_byte;
        end else if (byte_count == mbwrfr_pkg::POS_VALUE_LOW) begin
          held_value_next = s1_byte;
        end
        byte_count_next = byte_count + 3'd1;
        if (byte_count_next == mbwrfr_pkg::POS_CRC_LOW) begin
          phase_next = mbwrfr_pkg::PH_CRC;
        end
      end
      mbwrfr_pkg::PH_CRC: begin
        if (byte_count == mbwrfr_pkg::POS_CRC_LOW) begin
          crc_low_match_next = (s1_byte == crc_acc[7:0]);
          byte_count_next    = mbwrfr_pkg::POS_CRC_HIGH;
        end else begin
          res_valid          = 1'b1;
          res.frame_good     = crc_low_match && (s1_byte == crc_acc[15:8]);
          phase_next         = mbwrfr_pkg::PH_HUNT;
          byte_count_next    = 3'd0;
          crc_acc_next       = mbwrfr_pkg::CRC_INIT;
          crc_low_match_next = 1'b0;
        end
      end
      default: begin
        // Hunting, and any unused phase code behaves as hunting.
        crc_low_match_next = 1'b0;
        if (s1_byte == cfg.station_address) begin
          crc_acc_next    = mbwrfr_pkg::crc_feed(mbwrfr_pkg::CRC_INIT, s1_byte);
          byte_count_next = mbwrfr_pkg::POS_AFTER_ADDRESS;
          phase_next      = mbwrfr_pkg::PH_FUNC;
        end else begin
          phase_next      = mbwrfr_pkg::PH_HUNT;
          byte_count_next = 3'd0;
          crc_acc_next    = mbwrfr_pkg::CRC_INIT;
        end
      end
    endcase
  end

  // A byte is processed unless it completes a frame while the result
  // register is still full and stalled.
  assign advance  = s1_valid && (!res_valid || out_free);
  assign res_load = advance && res_valid;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= mbwrfr_pkg::PH_HUNT;
      byte_count    <= 3'd0;
      crc_acc       <= mbwrfr_pkg::CRC_INIT;
      held_register <= 8'h00;
      held_value    <= 8'h00;
      crc_low_match <= 1'b0;
    end else if (advance) begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      crc_acc       <= crc_acc_next;
      held_register <= held_register_next;
      held_value    <= held_value_next;
      crc_low_match <= crc_low_match_next;
    end
  end

  a_func_count: assert property (@(posedge clk) disable iff (rst)
    (phase == mbwrfr_pkg::PH_FUNC) |-> (byte_count == mbwrfr_pkg::POS_AFTER_ADDRESS))
    else $error("awaiting function code with wrong byte count");

  a_body_count: assert property (@(posedge clk) disable iff (rst)
    (phase == mbwrfr_pkg::PH_BODY) |-> (byte_count >= 3'd2 && byte_count <= 3'd5))
    else $error("body byte count out of range");

  a_crc_count: assert property (@(posedge clk) disable iff (rst)
    (phase == mbwrfr_pkg::PH_CRC) |->
      (byte_count == mbwrfr_pkg::POS_CRC_LOW || byte_count == mbwrfr_pkg::POS_CRC_HIGH))
    else $error("CRC byte count out of range");

  a_load_end: assert property (@(posedge clk) disable iff (rst)
    res_load |=> (phase == mbwrfr_pkg::PH_HUNT && byte_count == 3'd0 && !crc_low_match))
    else $error("frame end did not restart the hunt");

endmodule

`default_nettype wire

### rtl/core/mbwrfr_out_reg.sv
`default_nettype none

module mbwrfr_out_reg (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                res_load,
  input  wire mbwrfr_pkg::result_t res,
  output logic                     out_free,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     frame_good,
  output logic [7:0]               register_low,
  output logic [7:0]               value_low
);

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      frame_good   <= res.frame_good;
      register_low <= res.register_low;
      value_low    <= res.value_low;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !res_load)
    else $error("result overwritten while stalled");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(register_low) && $stable(value_low)))
    else $error("stalled result changed");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    res_load |=> out_valid)
    else $error("loaded result not presented");

endmodule

`default_nettype wire

### verif/testbench.sv
// Frame receiver testbench.
//
// Bytes are offered to the block one transaction at a time, and a software
// copy of the frame parser inside this module follows each accepted byte.
// The copy tracks the hunt for the station address, the function check, the
// running CRC and the held register and value bytes. Every completed frame
// places one expected result in a queue. A separate process takes each
// result transaction from the block and compares it, field by field, with
// the oldest entry in that queue.
//
// Both channels pause at random. The byte source may wait before each byte,
// and the result sink may hold off on each result. Some stretches run with
// no pauses at all, so that back-to-back traffic is exercised as well.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mbwrfr_pkg::*;

  // Far above the slowest legal run: about 1700 bytes, each after the longest
  // wait, plus the longest hold-off on every result.
  localparam int unsigned CYCLE_LIMIT     = 200000;
  // The block processes a byte from its input register and presents the
  // result from its output register; this margin lets any byte in flight land.
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned BYTES_PER_PHASE = 135;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0]             cfg_data  = '0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  logic [7:0]             rx_byte   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   frame_good;
  logic [7:0]             register_low;
  logic [7:0]             value_low;

  // Software copy of the parser state and of both configuration registers.
  logic [7:0]  rx_station  = STATION_ADDRESS_RESET;
  logic [7:0]  rx_function = EXPECTED_FUNCTION_RESET;
  phase_t      rx_phase    = PH_HUNT;
  logic [2:0]  rx_count    = '0;
  logic [15:0] rx_crc      = CRC_INIT;
  logic [7:0]  rx_register = '0;
  logic [7:0]  rx_value    = '0;
  logic        rx_low_ok   = 1'b0;

  // Results of completed frames that the block has not yet delivered.
  result_t pending_results[$];

  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned frame_bytes = 0;
  int unsigned stall_left  = 0;
  bit          no_idle     = 1'b0;

  modbus_write_register_frame_receiver_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_good   (frame_good),
    .register_low (register_low),
    .value_low    (value_low)
  );

  always begin
    #5;
    clk = 1'b1;
    #5;
    clk = 1'b0;
  end

  // One byte through the reflected Modbus CRC, least significant bit first.
  function automatic logic [15:0] modbus_crc_step(input logic [15:0] acc,
                                                  input logic [7:0] data);
    logic [15:0] c;
    c = acc ^ {8'h00, data};
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  // CRC over the address, function and four body bytes of a frame.
  function automatic logic [15:0] frame_crc(input logic [7:0] head [6]);
    logic [15:0] acc;
    acc = CRC_INIT;
    foreach (head[i]) acc = modbus_crc_step(acc, head[i]);
    return acc;
  endfunction

  function automatic void restart_hunt();
    rx_phase  = PH_HUNT;
    rx_count  = '0;
    rx_crc    = CRC_INIT;
    rx_low_ok = 1'b0;
  endfunction

  // Advances the software parser by one accepted byte. If the byte closes a
  // frame, the expected result is queued.
  function automatic void track_frame_byte(input logic [7:0] b);
    result_t done;
    case (rx_phase)
      PH_FUNC: begin
        // A wrong function code is dropped. It is not reconsidered as an
        // address, even when it equals the station address.
        if (b == rx_function) begin
          rx_crc   = modbus_crc_step(rx_crc, b);
          rx_count = POS_AFTER_FUNCTION;
          rx_phase = PH_BODY;
        end else begin
          restart_hunt();
        end
      end
      PH_BODY: begin
        rx_crc = modbus_crc_step(rx_crc, b);
        if (rx_count == POS_REGISTER_LOW) begin
          rx_register = b;
        end else if (rx_count == POS_VALUE_LOW) begin
          rx_value = b;
        end
        rx_count = rx_count + 3'd1;
        if (rx_count == POS_CRC_LOW) begin
          rx_phase = PH_CRC;
        end
      end
      PH_CRC: begin
        if (rx_count == POS_CRC_LOW) begin
          rx_low_ok = (b == rx_crc[7:0]);
          rx_count  = POS_CRC_HIGH;
        end else begin
          // A failed CRC still yields a result, flagged as bad.
          done.frame_good   = rx_low_ok && (b == rx_crc[15:8]);
          done.register_low = rx_register;
          done.value_low    = rx_value;
          pending_results.push_back(done);
          restart_hunt();
        end
      end
      default: begin
        if (b == rx_station) begin
          rx_crc   = modbus_crc_step(CRC_INIT, b);
          rx_count = POS_AFTER_ADDRESS;
          rx_phase = PH_FUNC;
        end else begin
          restart_hunt();
        end
      end
    endcase
  endfunction

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic void report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endfunction

  // Offers one byte and returns once the block has accepted it. The valid
  // is left high on return: the next call either lowers it for a gap or
  // keeps it high, so that it is never lowered and raised again in the same
  // step.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = draw_wait();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    track_frame_byte(b);
  endtask

  // Sends a whole frame. A non-zero flip corrupts the matching CRC bits.
  task automatic send_frame(input logic [7:0] head [6], input logic [15:0] flip);
    logic [15:0] crc;
    crc = frame_crc(head) ^ flip;
    foreach (head[i]) send_byte(head[i]);
    send_byte(crc[7:0]);
    send_byte(crc[15:8]);
    frame_bytes += 8;
  endtask

  // Stops offering bytes and waits until every expected result has been
  // delivered. Then it waits out the settle margin, so that a byte still being
  // processed inside the block has taken effect before the configuration
  // is changed.
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (index == REG_STATION_ADDRESS) begin
      rx_station = data;
    end else if (index == REG_EXPECTED_FUNCTION) begin
      rx_function = data;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Checks every result transaction against the oldest expectation. It then
  // draws how long the sink will hold off on the next result.
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result good %0b register %02h value %02h",
                                  frame_good, register_low, value_low));
      end else begin
        want = pending_results.pop_front();
        if (frame_good !== want.frame_good) begin
          report_mismatch($sformatf("frame_good expected %0b got %0b",
                                    want.frame_good, frame_good));
        end
        if (register_low !== want.register_low) begin
          report_mismatch($sformatf("register_low expected %02h got %02h",
                                    want.register_low, register_low));
        end
        if (value_low !== want.value_low) begin
          report_mismatch($sformatf("value_low expected %02h got %02h",
                                    want.value_low, value_low));
        end
      end
      stall_left = draw_wait();
    end
  end

  // The sink stalls only while a result is on offer, so that every drawn
  // hold-off really delays a result transaction.
  always @(negedge clk) begin
    if (out_valid && stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("modbus_write_register_frame_receiver_top regression: fail");
      $finish;
    end
  end

  // These frames use the reset configuration. They cover a good frame with
  // extreme body bytes and a wrong function code that equals the station
  // address. They also cover a bad low CRC byte and a bad high CRC byte.
  task automatic test_directed_frames();
    send_frame('{8'h01, 8'h06, 8'h00, 8'hFF, 8'hFF, 8'h00}, 16'h0000);
    // Only the first of the two address bytes opens the frame. The second
    // is dropped as a wrong function code, and the 0x06 after it is noise.
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h01);
    send_byte(8'h06);
    send_frame('{8'h01, 8'h06, 8'hFF, 8'h00, 8'h00, 8'hFF}, 16'h0001);
    send_frame('{8'h01, 8'h06, 8'h12, 8'h34, 8'h56, 8'h78}, 16'h8000);
  endtask

  // Both registers are taken to each end of their range. A frame that uses
  // the old address must then be ignored.
  task automatic test_register_extremes();
    settle_block();
    write_register(REG_STATION_ADDRESS, 8'h00);
    write_register(REG_EXPECTED_FUNCTION, 8'hFF);
    send_frame('{8'h01, 8'h06, 8'hA5, 8'h5A, 8'h3C, 8'hC3}, 16'h0000);
    send_frame('{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE}, 16'h0000);
    settle_block();
    write_register(REG_STATION_ADDRESS, 8'hFF);
    write_register(REG_EXPECTED_FUNCTION, 8'h00);
    send_frame('{8'hFF, 8'h00, 8'h0F, 8'hF0, 8'h55, 8'hAA}, 16'h0000);
  endtask

  // Registers are written while a frame is partly received. A new function
  // code applies to the function byte still to come. A new station address
  // must not disturb the frame that is already open.
  task automatic test_midframe_write();
    logic [7:0]  head [6];
    logic [15:0] crc;
    head = '{8'h5A, 8'h10, 8'h21, 8'h43, 8'h65, 8'h87};
    crc  = frame_crc(head);
    settle_block();
    write_register(REG_STATION_ADDRESS, 8'h5A);
    write_register(REG_EXPECTED_FUNCTION, 8'h06);
    send_byte(head[0]);
    settle_block();
    write_register(REG_EXPECTED_FUNCTION, 8'h10);
    send_byte(head[1]);
    settle_block();
    write_register(REG_STATION_ADDRESS, 8'h33);
    for (int i = 2; i < 6; i++) send_byte(head[i]);
    send_byte(crc[7:0]);
    send_byte(crc[15:8]);
  endtask

  // Random traffic in several configuration phases, the extremes first.
  // Most of it is well-formed frames with random bodies, some with a broken
  // CRC. The rest is cut-short frames, wrong function codes and line noise.
  task automatic test_random_traffic();
    logic [7:0]  head [6];
    logic [15:0] flip;
    int unsigned target;
    int unsigned pick;
    for (int phase_idx = 0; phase_idx < RANDOM_PHASES; phase_idx++) begin
      settle_block();
      case (phase_idx)
        0: begin
          write_register(REG_STATION_ADDRESS, 8'h00);
          write_register(REG_EXPECTED_FUNCTION, 8'hFF);
        end
        1: begin
          write_register(REG_STATION_ADDRESS, 8'hFF);
          write_register(REG_EXPECTED_FUNCTION, 8'h00);
        end
        2: begin
          write_register(REG_STATION_ADDRESS, STATION_ADDRESS_RESET);
          write_register(REG_EXPECTED_FUNCTION, EXPECTED_FUNCTION_RESET);
        end
        default: begin
          write_register(REG_STATION_ADDRESS, 8'($urandom_range(0, 255)));
          write_register(REG_EXPECTED_FUNCTION, 8'($urandom_range(0, 255)));
        end
      endcase
      target = frame_bytes + BYTES_PER_PHASE;
      while (frame_bytes < target) begin
        // One phase runs flat out. Elsewhere, short stretches with no idling
        // are mixed in among the paused ones.
        no_idle = (phase_idx == 4) || ($urandom_range(0, 5) == 0);
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          head[0] = rx_station;
          head[1] = rx_function;
          for (int i = 2; i < 6; i++) head[i] = 8'($urandom_range(0, 255));
          case ($urandom_range(0, 9))
            0:       flip = {8'h00, 8'($urandom_range(1, 255))};
            1:       flip = {8'($urandom_range(1, 255)), 8'h00};
            2:       flip = 16'($urandom_range(1, 65535));
            default: flip = 16'h0000;
          endcase
          send_frame(head, flip);
        end else if (pick < 7) begin
          // A frame cut short. Whatever follows is taken as its remaining
          // bytes.
          send_byte(rx_station);
          send_byte(rx_function);
          frame_bytes += 2;
          repeat ($urandom_range(0, 4)) begin
            send_byte(8'($urandom_range(0, 255)));
            frame_bytes++;
          end
        end else if (pick < 8) begin
          send_byte(rx_station);
          send_byte(8'($urandom_range(0, 255)));
          frame_bytes += 2;
        end else begin
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    stall_left = draw_wait();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_frames();
    test_register_extremes();
    test_midframe_write();
    test_random_traffic();
    settle_block();
    if (mismatches == 0) begin
      $display("modbus_write_register_frame_receiver_top regression: pass");
    end else begin
      $display("modbus_write_register_frame_receiver_top regression: fail");
    end
    $finish;
  end

endmodule
